// ===== hdl/rpc_pkg.sv =====
// rpc_pkg: shared types, register indexes and reset values for the RGBA
// pixel compositor. No dependencies.
`timescale 1ns / 1ps

package rpc_pkg;

    localparam int CHAN_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    typedef logic [CHAN_W-1:0] chan_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        chan_t alpha;
    } pixel_t;

    typedef enum logic [1:0] {
        MODE_COPY     = 2'd0,
        MODE_SRC_OVER = 2'd1,
        MODE_CONST    = 2'd2
    } blend_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLEND_MODE     = 2'd0,
        REG_DEST_IS_32BPP  = 2'd1,
        REG_DEST_HAS_ALPHA = 2'd2,
        REG_CONSTANT_ALPHA = 2'd3
    } cfg_index_t;

    // Raw mode field is kept so that the unused code can fall back to copy
    typedef struct packed {
        logic [1:0] blend_mode;
        logic       dest_is_32bpp;
        logic       dest_has_alpha;
        chan_t      constant_alpha;
    } cfg_t;

    localparam logic [1:0] RST_BLEND_MODE     = 2'd0;
    localparam logic       RST_DEST_IS_32BPP  = 1'b1;
    localparam logic       RST_DEST_HAS_ALPHA = 1'b1;
    localparam chan_t      RST_CONSTANT_ALPHA = 8'd150;
    localparam chan_t      CHAN_MAX           = 8'd255;

endpackage

// ===== hdl/rpc_cfg_regs.sv =====
// rpc_cfg_regs: configuration register bank behind the plain write port.
// Depends on rpc_pkg.
`timescale 1ns / 1ps

module rpc_cfg_regs
    import rpc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_BLEND_MODE:     cfg_next.blend_mode     = cfg_wdata[1:0];
                REG_DEST_IS_32BPP:  cfg_next.dest_is_32bpp  = cfg_wdata[0];
                REG_DEST_HAS_ALPHA: cfg_next.dest_has_alpha = cfg_wdata[0];
                REG_CONSTANT_ALPHA: cfg_next.constant_alpha = cfg_wdata[CHAN_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.blend_mode     <= RST_BLEND_MODE;
            cfg_reg.dest_is_32bpp  <= RST_DEST_IS_32BPP;
            cfg_reg.dest_has_alpha <= RST_DEST_HAS_ALPHA;
            cfg_reg.constant_alpha <= RST_CONSTANT_ALPHA;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/rpc_mix_byte.sv =====
// rpc_mix_byte: one channel of the blend, d + floor((a+1)*(s-d)/256) mod 256.
// Depends on rpc_pkg.
`timescale 1ns / 1ps

module rpc_mix_byte
    import rpc_pkg::*;
(
    input  chan_t alpha,
    input  chan_t src,
    input  chan_t dst,
    output chan_t mixed
);

    logic [CHAN_W:0]     diff;
    logic [2*CHAN_W-1:0] diff_ext;
    logic [2*CHAN_W-1:0] weight;
    logic [2*CHAN_W-1:0] prod;

    // Only bits 15:8 of the product survive, so a 16-bit two's complement
    // product gives the floor shift for free.
    assign diff     = {1'b0, src} - {1'b0, dst};
    assign diff_ext = {{(CHAN_W-1){diff[CHAN_W]}}, diff};
    assign weight   = {{CHAN_W{1'b0}}, alpha} + {{(2*CHAN_W-1){1'b0}}, 1'b1};
    assign prod     = diff_ext * weight;
    assign mixed    = dst + prod[2*CHAN_W-1:CHAN_W];

endmodule

// ===== hdl/rpc_blend_core.sv =====
// rpc_blend_core: mode decode and per-channel blend for one pixel pair.
// Depends on rpc_pkg and rpc_mix_byte.
`timescale 1ns / 1ps

module rpc_blend_core
    import rpc_pkg::*;
(
    input  cfg_t   cfg,
    input  pixel_t src,
    input  pixel_t dst,
    output pixel_t result
);

    blend_mode_t mode;
    chan_t       alpha;
    pixel_t      mixed;

    always_comb begin
        case (cfg.blend_mode)
            MODE_SRC_OVER: mode = cfg.dest_is_32bpp ? MODE_SRC_OVER : MODE_COPY;
            MODE_CONST:    mode = MODE_CONST;
            default:       mode = MODE_COPY;
        endcase
    end

    assign alpha = (mode == MODE_CONST) ? cfg.constant_alpha : src.alpha;

    rpc_mix_byte u_mix_red (
        .alpha (alpha), .src (src.red),   .dst (dst.red),   .mixed (mixed.red)
    );
    rpc_mix_byte u_mix_green (
        .alpha (alpha), .src (src.green), .dst (dst.green), .mixed (mixed.green)
    );
    rpc_mix_byte u_mix_blue (
        .alpha (alpha), .src (src.blue),  .dst (dst.blue),  .mixed (mixed.blue)
    );
    // alpha channel blends towards opaque
    rpc_mix_byte u_mix_alpha (
        .alpha (alpha), .src (CHAN_MAX),  .dst (dst.alpha), .mixed (mixed.alpha)
    );

    always_comb begin
        result = src;
        case (mode)
            MODE_SRC_OVER: begin
                if (src.alpha == CHAN_MAX) begin
                    result = src;
                end else if (src.alpha == '0) begin
                    result = dst;
                end else begin
                    result = mixed;
                end
            end
            MODE_CONST: begin
                result = mixed;
                if (!cfg.dest_has_alpha) begin
                    result.alpha = dst.alpha;
                end
            end
            default: result = src;
        endcase
    end

endmodule

// ===== hdl/rgba_pixel_compositor.sv =====
// rgba_pixel_compositor: top level, input register, blend core, result register.
// Depends on rpc_pkg, rpc_cfg_regs, rpc_blend_core.
//
//  channel | direction | handshake          | word
//  s_*     | in        | s_valid / s_ready  | source + destination pixel
//  m_*     | out       | m_valid / m_ready  | new destination pixel
//  cfg_*   | in        | cfg_wr_en          | register write, no read-back
//
// One word per cycle sustained while m_ready stays high; each word passes the input register, then the
// result register after the 9x9 multiply of each channel.
// The input stage may fill while the result stage holds; s_ready drops only when both hold a word and
// m_ready is low. Reset (aresetn, synchronous) empties both stages and loads
// the register defaults.
`timescale 1ns / 1ps

module rgba_pixel_compositor
    import rpc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  chan_t                s_src_red,
    input  chan_t                s_src_green,
    input  chan_t                s_src_blue,
    input  chan_t                s_src_alpha,
    input  chan_t                s_dst_red,
    input  chan_t                s_dst_green,
    input  chan_t                s_dst_blue,
    input  chan_t                s_dst_alpha,

    output logic                 m_valid,
    input  logic                 m_ready,
    output chan_t                m_out_red,
    output chan_t                m_out_green,
    output chan_t                m_out_blue,
    output chan_t                m_out_alpha
);

    cfg_t   cfg;
    logic   in_valid_reg;
    pixel_t in_src_reg;
    pixel_t in_dst_reg;
    logic   out_valid_reg;
    pixel_t out_pix_reg;
    pixel_t blend_next;
    logic   out_load;
    logic   in_load;

    rpc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rpc_blend_core u_core (
        .cfg    (cfg),
        .src    (in_src_reg),
        .dst    (in_dst_reg),
        .result (blend_next)
    );

    assign out_load = !out_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || out_load;
    assign in_load  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_load) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_src_reg <= '{s_src_red, s_src_green, s_src_blue, s_src_alpha};
            in_dst_reg <= '{s_dst_red, s_dst_green, s_dst_blue, s_dst_alpha};
        end
        if (out_load && in_valid_reg) begin
            out_pix_reg <= blend_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_out_red   = out_pix_reg.red;
    assign m_out_green = out_pix_reg.green;
    assign m_out_blue  = out_pix_reg.blue;
    assign m_out_alpha = out_pix_reg.alpha;

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while both stages are held");

    a_word_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_load) |=> m_valid)
        else $error("word lost between input and result register");

    a_copy_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_load && (cfg.blend_mode == MODE_COPY))
        |=> (m_out_red == $past(in_src_reg.red)) && (m_out_alpha == $past(in_src_reg.alpha)))
        else $error("copy mode did not pass the source through");
`endif

endmodule

// ===== tb/sv/rpc_checker.sv =====
// rpc_checker: watches the config port and both word channels of the pixel
// compositor, predicts each result word and compares it. Depends on rpc_pkg.
`timescale 1ns / 1ps

module rpc_checker
    import rpc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  pixel_t               s_src,
    input  pixel_t               s_dst,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  pixel_t               m_pix,
    output int                   fail_count,
    output int                   pending
);

    cfg_t   regs;
    pixel_t expected_pix_q[$];

    // d + floor((a+1)*(s-d)/256), mod 256: only bits 15:8 of the product matter
    function automatic chan_t mix_chan(chan_t a, chan_t s, chan_t d);
        logic [31:0] diff;
        logic [31:0] prod;
        diff = {24'd0, s} - {24'd0, d};
        prod = ({24'd0, a} + 32'd1) * diff;
        return d + prod[15:8];
    endfunction

    function automatic pixel_t composite(cfg_t c, pixel_t s, pixel_t d);
        pixel_t     r;
        logic [1:0] mode;
        r    = d;
        mode = c.blend_mode;
        if (mode == MODE_SRC_OVER && !c.dest_is_32bpp)
            mode = MODE_COPY;
        if (mode == MODE_SRC_OVER) begin
            if (s.alpha == CHAN_MAX) begin
                r = s;
            end else if (s.alpha != '0) begin
                r.red   = mix_chan(s.alpha, s.red, d.red);
                r.green = mix_chan(s.alpha, s.green, d.green);
                r.blue  = mix_chan(s.alpha, s.blue, d.blue);
                r.alpha = mix_chan(s.alpha, CHAN_MAX, d.alpha);
            end
        end else if (mode == MODE_CONST) begin
            r.red   = mix_chan(c.constant_alpha, s.red, d.red);
            r.green = mix_chan(c.constant_alpha, s.green, d.green);
            r.blue  = mix_chan(c.constant_alpha, s.blue, d.blue);
            if (c.dest_has_alpha)
                r.alpha = mix_chan(c.constant_alpha, CHAN_MAX, d.alpha);
        end else begin
            // copy, and the unused mode code
            r = s;
        end
        return r;
    endfunction

    task automatic check_chan(string field, chan_t want, chan_t got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        pixel_t want;
        if (!aresetn) begin
            regs.blend_mode     <= RST_BLEND_MODE;
            regs.dest_is_32bpp  <= RST_DEST_IS_32BPP;
            regs.dest_has_alpha <= RST_DEST_HAS_ALPHA;
            regs.constant_alpha <= RST_CONSTANT_ALPHA;
            expected_pix_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_BLEND_MODE:     regs.blend_mode     <= cfg_wdata[1:0];
                    REG_DEST_IS_32BPP:  regs.dest_is_32bpp  <= cfg_wdata[0];
                    REG_DEST_HAS_ALPHA: regs.dest_has_alpha <= cfg_wdata[0];
                    REG_CONSTANT_ALPHA: regs.constant_alpha <= cfg_wdata;
                    default: ;
                endcase
            end
            // retire before queueing so a same-edge word cannot match itself
            if (m_valid && m_ready) begin
                if (expected_pix_q.size() == 0) begin
                    $error("result word with nothing expected");
                    fail_count++;
                end else begin
                    want = expected_pix_q.pop_front();
                    check_chan("out_red",   want.red,   m_pix.red);
                    check_chan("out_green", want.green, m_pix.green);
                    check_chan("out_blue",  want.blue,  m_pix.blue);
                    check_chan("out_alpha", want.alpha, m_pix.alpha);
                end
            end
            if (s_valid && s_ready)
                expected_pix_q.push_back(composite(regs, s_src, s_dst));
        end
        pending <= expected_pix_q.size();
    end

endmodule

// ===== tb/sv/rgba_pixel_compositor_tb.sv =====
// rgba_pixel_compositor_tb: clock, reset, config writes and word stimulus for
// the pixel compositor, with rpc_checker alongside. Depends on rpc_pkg, rgba_pixel_compositor and rpc_checker.
`timescale 1ns / 1ps

module rgba_pixel_compositor_tb;
    import rpc_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         TAIL_CYCLES = 8;

    logic                 aclk;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [CFG_DAT_W-1:0] cfg_wdata   = '0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    pixel_t               src_drv     = '0;
    pixel_t               dst_drv     = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    pixel_t               m_pix;

    int fail_count;
    int pending;
    int tx_idle_pct = 28;
    int rx_idle_pct = 46;
    int cycles      = 0;

    rgba_pixel_compositor uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_src_red   (src_drv.red),
        .s_src_green (src_drv.green),
        .s_src_blue  (src_drv.blue),
        .s_src_alpha (src_drv.alpha),
        .s_dst_red   (dst_drv.red),
        .s_dst_green (dst_drv.green),
        .s_dst_blue  (dst_drv.blue),
        .s_dst_alpha (dst_drv.alpha),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_red   (m_pix.red),
        .m_out_green (m_pix.green),
        .m_out_blue  (m_pix.blue),
        .m_out_alpha (m_pix.alpha)
    );

    rpc_checker chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_src      (src_drv),
        .s_dst      (dst_drv),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_pix      (m_pix),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("rgba_pixel_compositor_tb: errors");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    function automatic pixel_t px(chan_t r, chan_t g, chan_t b, chan_t a);
        return '{red: r, green: g, blue: b, alpha: a};
    endfunction

    // called and returns at a falling edge; valid is left high after the word
    task automatic send_word(pixel_t s, pixel_t d);
        // each idle cycle drawn on its own, so the idle share matches the rate
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        src_drv <= s;
        dst_drv <= d;
        do
            @(posedge aclk);
        while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
    endtask

    task automatic set_config(logic [1:0] mode, logic bpp32, logic has_alpha,
                              chan_t const_alpha);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_BLEND_MODE;
        cfg_wdata <= CFG_DAT_W'(mode);
        @(negedge aclk);
        cfg_index <= REG_DEST_IS_32BPP;
        cfg_wdata <= CFG_DAT_W'(bpp32);
        @(negedge aclk);
        cfg_index <= REG_DEST_HAS_ALPHA;
        cfg_wdata <= CFG_DAT_W'(has_alpha);
        @(negedge aclk);
        cfg_index <= REG_CONSTANT_ALPHA;
        cfg_wdata <= const_alpha;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic pixel_t rand_pix();
        pixel_t p;
        int     pick;
        p    = pixel_t'($urandom);
        pick = $urandom_range(0, 9);
        // lean on the alpha shortcuts of source-over
        if (pick == 0)
            p.alpha = '0;
        else if (pick == 1)
            p.alpha = CHAN_MAX;
        return p;
    endfunction

    initial begin
        logic [1:0] mode;
        logic       bpp32;
        chan_t      calpha;

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset defaults: copy
        send_word(px(8'h00, 8'h00, 8'h00, 8'h00), px(8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_word(px(8'hFF, 8'hFF, 8'hFF, 8'hFF), px(8'h00, 8'h00, 8'h00, 8'h00));
        drain();

        set_config(MODE_SRC_OVER, 1'b1, 1'b1, 8'd150);
        send_word(px(8'h12, 8'h34, 8'h56, 8'hFF), px(8'h9A, 8'hBC, 8'hDE, 8'h11));
        send_word(px(8'h12, 8'h34, 8'h56, 8'h00), px(8'h9A, 8'hBC, 8'hDE, 8'h11));
        send_word(px(8'hFF, 8'hFF, 8'hFF, 8'h01), px(8'h00, 8'h00, 8'h00, 8'h00));
        send_word(px(8'h00, 8'h00, 8'h00, 8'hFE), px(8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_word(px(8'h00, 8'h80, 8'hFF, 8'h80), px(8'hFF, 8'h7F, 8'h00, 8'h00));
        drain();

        // source-over on a 16bpp destination degrades to copy
        set_config(MODE_SRC_OVER, 1'b0, 1'b1, 8'd150);
        send_word(px(8'h10, 8'h20, 8'h30, 8'h80), px(8'hF0, 8'hE0, 8'hD0, 8'h40));
        send_word(px(8'hAA, 8'h55, 8'h00, 8'hFF), px(8'h55, 8'hAA, 8'hFF, 8'h00));
        drain();

        // constant alpha 0 still nudges a colour down by one
        set_config(MODE_CONST, 1'b1, 1'b1, 8'd0);
        send_word(px(8'h00, 8'h10, 8'hFF, 8'h00), px(8'hFF, 8'h20, 8'h00, 8'h33));
        send_word(px(8'hFF, 8'hFF, 8'hFF, 8'hFF), px(8'h00, 8'h00, 8'h00, 8'hFF));
        drain();

        // constant alpha 255 on 16bpp lands on the source colours, alpha on opaque
        set_config(MODE_CONST, 1'b0, 1'b1, 8'd255);
        send_word(px(8'h00, 8'h7F, 8'hFF, 8'h00), px(8'hFF, 8'h80, 8'h00, 8'h00));
        send_word(px(8'h5A, 8'hA5, 8'h3C, 8'hC3), px(8'h00, 8'hFF, 8'h00, 8'hFF));
        drain();

        // no destination alpha: alpha passes through
        set_config(MODE_CONST, 1'b1, 1'b0, 8'd77);
        send_word(px(8'hFF, 8'h00, 8'h80, 8'hFF), px(8'h00, 8'hFF, 8'h80, 8'h42));
        send_word(px(8'h01, 8'hFE, 8'h40, 8'h00), px(8'hFE, 8'h01, 8'hC0, 8'h00));
        drain();

        // unused mode code behaves as copy
        set_config(MODE_UNUSED, 1'b1, 1'b1, 8'd150);
        send_word(px(8'h12, 8'h34, 8'h56, 8'h78), px(8'h87, 8'h65, 8'h43, 8'h21));
        send_word(px(8'hFF, 8'h00, 8'hFF, 8'h80), px(8'h00, 8'hFF, 8'h00, 8'h80));
        drain();

        for (int k = 0; k < 13; k++) begin
            if (k == 5) begin
                tx_idle_pct = 46;
                rx_idle_pct = 28;
            end else if (k == 9) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            mode  = (k < 8) ? 2'(k % 4) : 2'($urandom_range(0, 3));
            bpp32 = (k < 4) ? 1'b1 : (k < 8) ? 1'b0 : 1'($urandom);
            case (k % 3)
                0:       calpha = '0;
                1:       calpha = CHAN_MAX;
                default: calpha = chan_t'($urandom);
            endcase
            set_config(mode, bpp32, 1'($urandom), calpha);
            for (int i = 0; i < 50; i++) begin
                if (k == 6 && i == 25)
                    drain();
                send_word(rand_pix(), pixel_t'($urandom));
            end
            drain();
        end

        if (fail_count == 0 && pending == 0)
            $display("rgba_pixel_compositor_tb: clean");
        else
            $display("rgba_pixel_compositor_tb: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/rpc_pkg.sv
hdl/rpc_cfg_regs.sv
hdl/rpc_mix_byte.sv
hdl/rpc_blend_core.sv
hdl/rgba_pixel_compositor.sv
tb/sv/rpc_checker.sv
tb/sv/rgba_pixel_compositor_tb.sv
